>>> src/form_text_url_decode_validate_defines.svh
// ----------------------------------------------------------------------------
// Form text URL decoder: assertion macros
// Shared macros for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef FORM_TEXT_URL_DECODE_VALIDATE_DEFINES_SVH
`define FORM_TEXT_URL_DECODE_VALIDATE_DEFINES_SVH

// Check that is switched off while reset is held
`define FUV_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds across reset
`define FUV_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fuv_pkg.sv
// ----------------------------------------------------------------------------
// Form text URL decoder package
// Character constants and the command format between front and back end.
// ----------------------------------------------------------------------------
package fuv_pkg;

  // Characters of interest
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharEquals  = 8'h3D;
  localparam logic [7:0] CharLowE    = 8'h65;
  localparam logic [7:0] CharLowT    = 8'h74;
  localparam logic [7:0] CharLowX    = 8'h78;

  // Printable range for the text check
  localparam logic [7:0] PrintLow  = 8'd32;
  localparam logic [7:0] PrintHigh = 8'd126;

  // Reset value of the line length register
  localparam logic [7:0] MaxLineReset = 8'd80;

  // Most results that one body byte can cause
  localparam int unsigned MaxOps = 3;

  // Command kinds passed to the back end
  typedef enum logic {
    OP_BYTE,
    OP_VERDICT
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic        key_found;  // verdict only
    logic [7:0]  data;       // decoded byte only
  } op_t;

  // One queue entry: the commands caused by one body byte, in order
  typedef struct packed {
    logic [1:0]         count;
    op_t [MaxOps-1:0]   ops;
  } bundle_t;

endpackage

>>> src/fuv_front.sv
// ----------------------------------------------------------------------------
// Form text URL decoder: front end
// Searches for the key, tracks percent escapes and turns each body byte
// into a bundle of byte and verdict commands for the back end.
// ----------------------------------------------------------------------------
module fuv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [7:0]        s_byte_i,
  input  logic              s_last_i,
  output logic              push_o,
  output fuv_pkg::bundle_t  push_data_o,
  input  logic              full_i
);
  import fuv_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PERCENT,
    PH_HELD
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.valid = 1'b1;
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.valid = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    hex_t h;
    hex_t l;
    h = hex_value(hi);
    l = hex_value(lo);
    if (!h.valid) return 8'h00;
    if (!l.valid) return {4'h0, h.value};
    return {h.value, l.value};
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CharPlus) ? CharSpace : c;
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = CharLowT;
      3'd1:    r = CharLowE;
      3'd2:    r = CharLowX;
      3'd3:    r = CharLowT;
      default: r = CharEquals;
    endcase
    return r;
  endfunction

  phase_e     phase_q, phase_d;
  logic [7:0] esc_q, esc_d;
  logic [2:0] kpos_q, kpos_d;
  logic       kfound_q, kfound_d;
  logic       ended_q, ended_d;

  logic       accept;
  logic [1:0] pre_n;
  logic [7:0] pre_b0, pre_b1;
  logic [1:0] n_bytes;
  logic [7:0] b0, b1;
  logic [2:0] pos;
  bundle_t    bnd;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && !full_i;

  // Decode of one body byte
  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    kpos_d   = kpos_q;
    kfound_d = kfound_q;
    ended_d  = ended_q;
    pre_n    = 2'd0;
    pre_b0   = CharPercent;
    pre_b1   = plain_byte(esc_q);
    pos      = kpos_q;
    if (!ended_q) begin
      if (s_byte_i == CharNul) begin
        // content ends; flush a short escape
        case (phase_q)
          PH_PERCENT: pre_n = 2'd1;
          PH_HELD:    pre_n = 2'd2;
          default:    pre_n = 2'd0;
        endcase
        phase_d = PH_IDLE;
        ended_d = 1'b1;
      end else if (!kfound_q) begin
        if (pos > 3'd4) pos = 3'd0;
        if (s_byte_i == key_char(pos)) begin
          pos = pos + 3'd1;
        end else if (pos == 3'd4 && s_byte_i == CharLowE) begin
          pos = 3'd2;
        end else begin
          pos = (s_byte_i == CharLowT) ? 3'd1 : 3'd0;
        end
        if (pos == 3'd5) begin
          kfound_d = 1'b1;
          pos      = 3'd0;
        end
        kpos_d = pos;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (s_byte_i == CharPercent) begin
              phase_d = PH_PERCENT;
            end else begin
              pre_n  = 2'd1;
              pre_b0 = plain_byte(s_byte_i);
            end
          end
          PH_PERCENT: begin
            esc_d   = s_byte_i;
            phase_d = PH_HELD;
          end
          default: begin
            pre_n   = 2'd1;
            pre_b0  = hex_pair(esc_q, s_byte_i);
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    // Final byte: flush what is left of an escape; only one source is ever non-empty
    n_bytes = pre_n;
    b0      = pre_b0;
    b1      = pre_b1;
    if (s_last_i && pre_n == 2'd0) begin
      b0 = CharPercent;
      b1 = plain_byte(esc_d);
      case (phase_d)
        PH_PERCENT: n_bytes = 2'd1;
        PH_HELD:    n_bytes = 2'd2;
        default:    n_bytes = 2'd0;
      endcase
    end

    // Assemble the bundle
    bnd = '0;
    bnd.ops[0] = '{kind: OP_BYTE, key_found: 1'b0, data: b0};
    bnd.ops[1] = '{kind: OP_BYTE, key_found: 1'b0, data: b1};
    bnd.count  = n_bytes;
    if (s_last_i) begin
      case (n_bytes)
        2'd0:    bnd.ops[0] = '{kind: OP_VERDICT, key_found: kfound_d, data: 8'h00};
        2'd1:    bnd.ops[1] = '{kind: OP_VERDICT, key_found: kfound_d, data: 8'h00};
        default: bnd.ops[2] = '{kind: OP_VERDICT, key_found: kfound_d, data: 8'h00};
      endcase
      bnd.count = n_bytes + 2'd1;
      // next byte starts a new body
      phase_d  = PH_IDLE;
      esc_d    = 8'h00;
      kpos_d   = 3'd0;
      kfound_d = 1'b0;
      ended_d  = 1'b0;
    end
  end

  assign push_o      = accept && (bnd.count != 2'd0);
  assign push_data_o = bnd;

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      esc_q    <= 8'h00;
      kpos_q   <= 3'd0;
      kfound_q <= 1'b0;
      ended_q  <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      kpos_q   <= kpos_d;
      kfound_q <= kfound_d;
      ended_q  <= ended_d;
    end
  end

endmodule

>>> src/fuv_queue.sv
// ----------------------------------------------------------------------------
// Form text URL decoder: command queue
// Small register FIFO of command bundles between front and back end.
// ----------------------------------------------------------------------------
module fuv_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fuv_pkg::bundle_t  push_data_i,
  input  logic              pop_i,
  output fuv_pkg::bundle_t  head_o,
  output logic              full_o,
  output logic              empty_o
);
  import fuv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> src/fuv_back.sv
// ----------------------------------------------------------------------------
// Form text URL decoder: back end
// Walks the commands of each bundle, checks decoded text for printable
// characters and line length, and drives the registered result stream.
// ----------------------------------------------------------------------------
module fuv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fuv_pkg::bundle_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [7:0]        max_len_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [7:0]        m_byte_o,
  output logic              m_present_o,
  output logic              m_ok_o,
  output logic              m_last_o
);
  import fuv_pkg::*;

  logic [1:0] idx_q;
  logic [7:0] line_q, line_d;
  logic       valid_q, valid_d;
  logic       stop_q, stop_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_present_q, out_ok_q, out_last_q;

  logic       load;
  logic       last_op;
  op_t        op;
  logic [7:0] line_inc;

  assign load    = !empty_i && (!out_valid_q || m_ready_i);
  assign op      = head_i.ops[idx_q];
  assign last_op = (idx_q == head_i.count - 2'd1);
  assign pop_o   = load && last_op;

  // Text check on the command being issued
  always_comb begin
    line_d   = line_q;
    valid_d  = valid_q;
    stop_d   = stop_q;
    line_inc = (line_q == 8'hFF) ? line_q : line_q + 8'd1;
    if (op.kind == OP_VERDICT) begin
      line_d  = 8'h00;
      valid_d = 1'b1;
      stop_d  = 1'b0;
    end else if (!stop_q) begin
      if (op.data == CharNul) begin
        stop_d = 1'b1;
      end else if (op.data == CharNewline) begin
        line_d = 8'h00;
      end else if (op.data < PrintLow || op.data > PrintHigh) begin
        valid_d = 1'b0;
      end else begin
        line_d = line_inc;
        if (line_inc > max_len_i) valid_d = 1'b0;
      end
    end
  end

  // Check state, command index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      line_q      <= 8'h00;
      valid_q     <= 1'b1;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last_op ? 2'd0 : idx_q + 2'd1;
        line_q      <= line_d;
        valid_q     <= valid_d;
        stop_q      <= stop_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q    <= (op.kind == OP_BYTE) ? op.data : 8'h00;
      out_present_q <= (op.kind == OP_BYTE);
      out_ok_q      <= (op.kind == OP_VERDICT) && op.key_found && valid_q;
      out_last_q    <= (op.kind == OP_VERDICT);
    end
  end

  assign m_valid_o   = out_valid_q;
  assign m_byte_o    = out_byte_q;
  assign m_present_o = out_present_q;
  assign m_ok_o      = out_ok_q;
  assign m_last_o    = out_last_q;

endmodule

>>> src/form_text_url_decode_validate.sv
// Path: a body byte's results are written into the queue, then into the registered output stage.
// Throughput: one body byte per cycle while the queue is not full; a byte that causes
// up to three results sends them one at a time through the single output register, the queue absorbs bursts.
// Reset: asynchronous, active low; clears the decoder, queue, check state and
// output valid, and sets the line length limit to 80.
// ----------------------------------------------------------------------------
// Form text URL decoder with validation
// Finds "text=" in a form body, URL-decodes the rest, checks the text and
// reports a verdict on the last byte.
// ----------------------------------------------------------------------------
module form_text_url_decode_validate #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // line length register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // body stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  logic        s_axis_tlast,   // body_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] text_byte, [8] verdict_ok, zero above
  output logic        m_axis_tuser,   // [0] text_byte_present
  output logic        m_axis_tlast    // result_last
);
  import fuv_pkg::*;

  logic       push, pop, full, empty;
  bundle_t    push_data, head;
  logic [7:0] max_len_q;
  logic [7:0] out_byte;
  logic       out_ok;

  // Line length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLineReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  fuv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_byte_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  fuv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  fuv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .max_len_i   (max_len_q),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (out_byte),
    .m_present_o (m_axis_tuser),
    .m_ok_o      (out_ok),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'h00, out_ok, out_byte};

endmodule

>>> src/fuv_checker.sv
// ----------------------------------------------------------------------------
// Form text URL decoder: port checker
// Watches the result stream for well-formed byte and verdict transactions.
// ----------------------------------------------------------------------------
`include "form_text_url_decode_validate_defines.svh"

module fuv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [7:0]  cfg_wdata_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds
  `FUV_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Verdict transactions carry no text byte
  `FUV_ASSERT(a_verdict_form, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && m_axis_tdata[7:0] == 8'h00, "malformed verdict")

  // Every transaction is either a text byte or a verdict, and a byte has no pass flag
  `FUV_ASSERT(a_byte_form, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser && !m_axis_tdata[8], "malformed text byte")

  // Nothing is offered in the cycle after reset
  `FUV_ASSERT_ALWAYS(a_reset_idle, clk_i, !$past(rst_ni) |-> !m_axis_tvalid, "result valid out of reset")

endmodule

bind form_text_url_decode_validate fuv_checker u_fuv_checker (.*);

>>> tb/fuv_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Form text URL decoder: result checker
// Watches the body and result streams and the line limit register. It keeps
// its own copy of the decoder state, works out the results of each body
// byte, and compares every result transaction with the oldest one waiting.
// ----------------------------------------------------------------------------
module fuv_result_checker
  import fuv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  logic        s_axis_tlast,   // body_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] text_byte, [8] verdict_ok, zero above
  input  logic        m_axis_tuser,   // [0] text_byte_present
  input  logic        m_axis_tlast,   // result_last
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          clean_verdicts_o
);

  localparam int MaxReports = 10;

  // Key bytes, first one in the lowest lane
  localparam logic [4:0][7:0] KeyText = {CharEquals, CharLowT, CharLowX, CharLowE, CharLowT};

  typedef enum logic [1:0] {
    EscIdle,
    EscPercent,
    EscHeld
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] text;
    logic       present;
    logic       ok;
    logic       last;
  } text_result_t;

  text_result_t expected_text_q[$];

  // Decoder state
  logic [7:0] line_limit;
  logic [2:0] key_pos;
  logic       key_found;
  esc_phase_e esc_phase;
  logic [7:0] esc_first;
  logic [7:0] line_len;
  logic       text_ok;
  logic       check_off;
  logic       body_done;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] form_plain(input logic [7:0] c);
    return (c == CharPlus) ? CharSpace : c;
  endfunction

  task automatic clear_body_state();
    key_pos   = '0;
    key_found = 1'b0;
    esc_phase = EscIdle;
    esc_first = '0;
    line_len  = '0;
    text_ok   = 1'b1;
    check_off = 1'b0;
    body_done = 1'b0;
  endtask

  // Emit one decoded byte and run the text check on it
  task automatic push_text_byte(input logic [7:0] b);
    if (!check_off) begin
      if (b == CharNul) begin
        check_off = 1'b1;
      end else if (b == CharNewline) begin
        line_len = '0;
      end else if (b < PrintLow || b > PrintHigh) begin
        text_ok = 1'b0;
      end else begin
        if (line_len != 8'hFF) line_len++;
        if (line_len > line_limit) text_ok = 1'b0;
      end
    end
    expected_text_q.push_back('{text: b, present: 1'b1, ok: 1'b0, last: 1'b0});
  endtask

  // A '%' cut short by the end of the content comes out as it stands
  task automatic flush_escape();
    if (esc_phase != EscIdle) push_text_byte(CharPercent);
    if (esc_phase == EscHeld) push_text_byte(form_plain(esc_first));
    esc_phase = EscIdle;
  endtask

  task automatic decode_body_byte(input logic [7:0] c, input logic body_last);
    int         hi;
    int         lo;
    logic [2:0] pos;
    if (!body_done) begin
      if (c == CharNul) begin
        flush_escape();
        body_done = 1'b1;
      end else if (!key_found) begin
        // substring search for the key, with the "texte" overlap
        pos = key_pos;
        if (c == KeyText[pos]) pos++;
        else if (pos == 3'd4 && c == CharLowE) pos = 3'd2;
        else pos = (c == CharLowT) ? 3'd1 : 3'd0;
        if (pos == 3'd5) begin
          key_found = 1'b1;
          pos = 3'd0;
        end
        key_pos = pos;
      end else begin
        case (esc_phase)
          EscIdle: begin
            if (c == CharPercent) esc_phase = EscPercent;
            else push_text_byte(form_plain(c));
          end
          EscPercent: begin
            esc_first = c;
            esc_phase = EscHeld;
          end
          default: begin
            hi = hex_nibble(esc_first);
            lo = hex_nibble(c);
            if (hi < 0) push_text_byte(8'h00);
            else if (lo < 0) push_text_byte(8'(hi));
            else push_text_byte({hi[3:0], lo[3:0]});
            esc_phase = EscIdle;
          end
        endcase
      end
    end
    if (body_last) begin
      flush_escape();
      expected_text_q.push_back('{text: 8'h00, present: 1'b0, ok: key_found && text_ok,
                                  last: 1'b1});
      clear_body_state();
    end
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    text_result_t want;
    logic         bad;
    if (!rst_ni) begin
      line_limit = MaxLineReset;
      clear_body_state();
      expected_text_q.delete();
      fail_count_o     = 0;
      checked_o        = 0;
      clean_verdicts_o = 0;
    end else begin
      if (cfg_we_i) line_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) decode_body_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (expected_text_q.size() == 0) begin
          if (fail_count_o < MaxReports)
            $display("[%0t] unexpected result: tdata %04h tuser %0b tlast %0b",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count_o++;
        end else begin
          want = expected_text_q.pop_front();
          bad  = (m_axis_tdata[7:0] != want.text) || (m_axis_tdata[8] != want.ok) ||
                 (m_axis_tdata[15:9] != '0) || (m_axis_tuser != want.present) ||
                 (m_axis_tlast != want.last);
          if (bad) begin
            if (fail_count_o < MaxReports) begin
              $write("[%0t] result mismatch: expected byte %02h ok %0b present %0b last %0b, ",
                     $time, want.text, want.ok, want.present, want.last);
              $display("got tdata %04h present %0b last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            fail_count_o++;
          end else if (want.last && want.ok) begin
            clean_verdicts_o++;
          end
        end
      end
    end
    pending_o = expected_text_q.size();
  end

endmodule

>>> tb/tb_form_text_url_decode_validate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Form text URL decoder testbench
// Drives form bodies into the decoder, first a few hand-made ones, then
// random bodies under several line limits, with random gaps on both streams
// and one long output stall. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_form_text_url_decode_validate;
  import fuv_pkg::*;

  // Guard on the length of the whole run, with plenty of margin
  localparam int CycleLimit   = 400000;
  localparam int LongHold     = 120;
  localparam int PhaseItems   = 42;
  localparam int NumPhases    = 5;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [7:0]  cfg_wdata     = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int checked;
  int clean_verdicts;

  int   cycle_count   = 0;
  int   items_sent    = 0;
  int   bodies_sent   = 0;
  logic tx_idle_en    = 1'b0;
  logic rx_idle_en    = 1'b0;
  logic long_hold_req = 1'b0;

  logic [7:0] body_q[$];

  always #2 clk_i = ~clk_i;

  form_text_url_decode_validate i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  fuv_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .clean_verdicts_o (clean_verdicts)
  );

  // Gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  // Offer one byte and hold it until the block takes it
  task automatic send_body_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_body_byte(body_q[i], i == body_q.size() - 1);
    body_q.delete();
    bodies_sent++;
  endtask

  // Let every expected result drain from the pipeline
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_line_limit(input logic [7:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed bodies with random content, some noise and bad keys
  task automatic build_random_body();
    int kind;
    int t;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) body_q.push_back(pick_from("textx=&a"));
      if (kind < 20) load_text(kind[0] ? "texx=" : "tex=");
      else load_text("text=");
      repeat ($urandom_range(1, 12)) begin
        t = $urandom_range(0, 99);
        if (t < 38) begin
          body_q.push_back(pick_printable());
        end else if (t < 48) begin
          body_q.push_back(CharPlus);
        end else if (t < 56) begin
          body_q.push_back(CharNewline);
        end else if (t < 76) begin
          body_q.push_back(CharPercent);
          body_q.push_back(pick_from("0123456789abcdefABCDEF"));
          body_q.push_back(pick_from("0123456789abcdefABCDEF"));
        end else if (t < 82) begin
          body_q.push_back(CharPercent);
          body_q.push_back(pick_from("0123456789abcdefABCDEF"));
          body_q.push_back(pick_from("gxzGXZ-+ .~%"));
        end else if (t < 87) begin
          body_q.push_back(CharPercent);
          body_q.push_back(8'($urandom_range(0, 255)));
          body_q.push_back(8'($urandom_range(0, 255)));
        end else if (t < 95) begin
          body_q.push_back(8'($urandom_range(1, 255)));
        end else begin
          body_q.push_back(CharNul);
        end
      end
      // sometimes end on an unfinished escape
      t = $urandom_range(0, 9);
      if (t < 2) body_q.push_back(CharPercent);
      if (t == 1) body_q.push_back(pick_from("0aF+%z"));
    end
  endtask

  // Result side: random stalls, and one long hold when asked for
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int         phase_start;
    logic [7:0] limit;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Hand-made bodies at the reset line limit: key overlap, plus, hex in
    // both cases, a lone hex digit, and a '%' cut off by the final byte
    load_text("textext=+%4a%Bz%");
    send_body();
    // held escape byte flushed by a raw zero; bytes after it are dropped
    load_text("text=%G");
    body_q.push_back(CharNul);
    body_q.push_back(8'hFF);
    send_body();
    wait_idle();

    // Line limit of one: a decoded zero ends the check, then an overlong line
    write_line_limit(8'd1);
    load_text("text=a\n%zzbc");
    send_body();
    load_text("text=ab");
    send_body();
    wait_idle();

    // Random bodies under several limits, with and without idling
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       limit = 8'd255;
        1:       limit = 8'd3;
        3:       limit = 8'd1;
        4:       limit = MaxLineReset;
        default: limit = 8'($urandom_range(1, 255));
      endcase
      write_line_limit(limit);
      tx_idle_en = (p > 1);
      rx_idle_en = (p != 0);
      if (p == 1) long_hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        build_random_body();
        send_body();
      end
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    $display("Sent %0d body bytes in %0d bodies over %0d line limits, stalls and idles included.",
             items_sent, bodies_sent, NumPhases + 2);
    $display("Checked %0d results, %0d of the verdicts clean, %0d failures.",
             checked, clean_verdicts, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
